### design/hep_pkg.sv
// shared types, constants and tables for the hamming embedding posting scorer
`default_nettype none
package hep_pkg;

  localparam int SIG_BITS = 64;
  localparam int DOC_BITS = 24;
  localparam int MAX_RUN  = 255;

  localparam int SIG_W    = 64;
  localparam int WEIGHT_W = 32;
  localparam int FACTOR_W = 17;
  localparam int DOCF_W   = 24;
  localparam int AMT_W    = 41;
  localparam int SUM_W    = 40;
  localparam int THR_W    = 7;
  localparam int CNT_W    = $clog2(MAX_RUN + 1);
  localparam int RUN_DEPTH = MAX_RUN + 1;
  localparam int DOC_W    = (DOC_BITS < DOCF_W) ? DOC_BITS : DOCF_W;

  // input beat layout
  localparam int QSIG_LSB   = 0;
  localparam int WEIGHT_LSB = QSIG_LSB + SIG_W;
  localparam int FACTOR_LSB = WEIGHT_LSB + WEIGHT_W;
  localparam int DOC_LSB    = FACTOR_LSB + FACTOR_W;
  localparam int DSIG_LSB   = DOC_LSB + DOCF_W;
  localparam int IN_BITS    = DSIG_LSB + SIG_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // output beat layout
  localparam int ODOC_LSB    = 0;
  localparam int OAMT_LSB    = ODOC_LSB + DOCF_W;
  localparam int OUT_BITS    = OAMT_LSB + AMT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_THR = CFG_IDX_W'(1);
  localparam logic [THR_W-1:0] SCORE_THR_RESET   = THR_W'(24);
  localparam logic [THR_W-1:0] SPATIAL_THR_RESET = THR_W'(28);

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_SCORE  = 1'b1;

  localparam logic [SIG_W-1:0] SIG_MASK = {SIG_W{1'b1}} >> (SIG_W - SIG_BITS);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [AMT_W-1:0] NEG_ONE_Q16 = AMT_W'(0) - AMT_W'(65536);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one queued posting: what the back end has to emit for it
  typedef struct packed {
    logic                pre_flush;
    logic [DOC_W-1:0]    pre_doc;
    logic [SUM_W-1:0]    pre_sum;
    logic [CNT_W-1:0]    pre_cnt;
    logic [AMT_W-1:0]    weight_amt;
    logic [DOC_W-1:0]    doc;
    logic                post_flush;
    logic [SUM_W-1:0]    post_sum;
    logic [CNT_W-1:0]    post_cnt;
    logic [FACTOR_W-1:0] factor;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [FACTOR_W-1:0] rsqrt_rom_t [RUN_DEPTH];

  // largest r with r*r*n <= 2^32, evaluated at elaboration
  function automatic rsqrt_rom_t build_rsqrt_rom();
    rsqrt_rom_t rom;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    for (int n = 0; n < RUN_DEPTH; n++) begin
      lo = 0;
      hi = 65536;
      if (n == 0) begin
        lo = 65536;
      end else begin
        for (int k = 0; k < 18; k++) begin
          if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * 64'(n) <= 64'h1_0000_0000) lo = mid;
            else hi = mid - 1;
          end
        end
      end
      rom[n] = FACTOR_W'(lo);
    end
    return rom;
  endfunction

  localparam rsqrt_rom_t RSQRT_ROM = build_rsqrt_rom();

  // byte counts first, then a short sum of eight
  function automatic logic [THR_W-1:0] popcount64(input logic [SIG_W-1:0] x);
    logic [3:0]       byte_cnt [8];
    logic [THR_W-1:0] total;
    total = '0;
    for (int b = 0; b < 8; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(x[b*8+i]);
      end
    end
    for (int b = 0; b < 8; b++) begin
      total = total + THR_W'(byte_cnt[b]);
    end
    return total;
  endfunction

endpackage
`default_nettype wire

### design/hep_front.sv
// front end: posting intake, hamming distance, per-document run tracking
`default_nettype none
module hep_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // query_signature, word_weight, query_count_factor, doc_id, db_signature
  input  wire logic [hep_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                           s_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hep_pkg::THR_W-1:0]      cfg_data,
  output logic                                push,
  output hep_pkg::job_t                       push_job,
  input  wire hep_pkg::q_stat_t               q_stat
);
  import hep_pkg::*;

  logic [THR_W-1:0] score_thr;
  logic [THR_W-1:0] spatial_thr;

  // distance stage
  logic                s1_valid;
  logic [THR_W-1:0]    s1_dist;
  logic [WEIGHT_W-1:0] s1_weight;
  logic [FACTOR_W-1:0] s1_factor;
  logic [DOC_W-1:0]    s1_doc;
  logic                s1_last;
  logic                s1_go;
  logic                in_take;

  // run state
  logic             run_open;
  logic [DOC_W-1:0] run_doc;
  logic [SUM_W-1:0] run_sum;
  logic [CNT_W-1:0] run_count;

  logic             doc_change;
  logic             keep_run;
  logic [SUM_W-1:0] base_sum;
  logic [CNT_W-1:0] base_cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_next;
  logic             spatial_hit;
  logic             score_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr   <= SCORE_THR_RESET;
      spatial_thr <= SPATIAL_THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCORE_THR:   score_thr   <= cfg_data;
        REG_SPATIAL_THR: spatial_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_go    = s1_valid && !q_stat.full;
  assign s_tready = !s1_valid || s1_go;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_dist   <= popcount64((s_tdata[QSIG_LSB +: SIG_W] ^ s_tdata[DSIG_LSB +: SIG_W])
                              & SIG_MASK);
      s1_weight <= s_tdata[WEIGHT_LSB +: WEIGHT_W];
      s1_factor <= s_tdata[FACTOR_LSB +: FACTOR_W];
      s1_doc    <= s_tdata[DOC_LSB +: DOC_W];
      s1_last   <= s_tlast;
    end
  end

  always_comb begin
    doc_change  = run_open && (s1_doc != run_doc);
    keep_run    = run_open && !doc_change;
    base_sum    = keep_run ? run_sum : '0;
    base_cnt    = keep_run ? run_count : '0;
    cnt_next    = (base_cnt < CNT_W'(MAX_RUN)) ? base_cnt + CNT_W'(1) : base_cnt;
    spatial_hit = s1_dist <= spatial_thr;
    score_hit   = spatial_hit && (s1_dist <= score_thr);
    sum_wide    = {1'b0, base_sum} + (SUM_W + 1)'(s1_weight);
    if (!score_hit) sum_next = base_sum;
    else if (sum_wide[SUM_W]) sum_next = SUM_MAX;
    else sum_next = sum_wide[SUM_W-1:0];

    push                = s1_go;
    push_job.pre_flush  = doc_change;
    push_job.pre_doc    = run_doc;
    push_job.pre_sum    = run_sum;
    push_job.pre_cnt    = run_count;
    push_job.weight_amt = spatial_hit ? AMT_W'(s1_weight) : NEG_ONE_Q16;
    push_job.doc        = s1_doc;
    push_job.post_flush = s1_last;
    push_job.post_sum   = sum_next;
    push_job.post_cnt   = cnt_next;
    push_job.factor     = s1_factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      run_doc   <= '0;
      run_sum   <= '0;
      run_count <= '0;
    end else if (s1_go) begin
      run_doc <= s1_doc;
      if (s1_last) begin
        run_open  <= 1'b0;
        run_sum   <= '0;
        run_count <= '0;
      end else begin
        run_open  <= 1'b1;
        run_sum   <= sum_next;
        run_count <= cnt_next;
      end
    end
  end

  a_closed_run_empty: assert property (@(posedge clk) disable iff (rst)
    !run_open |-> (run_count == '0) && (run_sum == '0))
    else $error("closed run holds data");

  a_open_run_counted: assert property (@(posedge clk) disable iff (rst)
    run_open |-> (run_count != '0))
    else $error("open run with zero count");

  a_list_end_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> !run_open)
    else $error("run still open after list end");

endmodule
`default_nettype wire

### design/hep_queue.sv
// short job queue between front end and back end
`default_nettype none
module hep_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire hep_pkg::job_t push_job,
  input  wire logic       pop,
  output hep_pkg::job_t   head,
  output hep_pkg::q_stat_t q_stat
);
  import hep_pkg::*;

  job_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head         = entry[rd_ptr];
  assign q_stat.full  = count == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (push && !pop) count <= count + Q_CNT_W'(1);
      else if (pop && !push) count <= count - Q_CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

### design/hep_back.sv
// back end: result sequencer with the two-step run contribution multiply
`default_nettype none
module hep_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hep_pkg::q_stat_t                q_stat,
  input  wire hep_pkg::job_t                   head,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // result_doc, amount
  output logic [hep_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // kind
  output logic [0:0]                           m_tuser,
  output logic                                 m_tlast
);
  import hep_pkg::*;

  localparam int MUL1_W = SUM_W + FACTOR_W;
  localparam int P1_W   = MUL1_W - 16;
  localparam int MUL2_W = P1_W + FACTOR_W;
  localparam int P2_W   = MUL2_W - 16;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PLAN = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_SEND = 5'b10000
  } state_t;

  state_t              state;
  job_t                job;
  logic                pend_pre;
  logic                pend_w;
  logic                pend_post;
  logic [SUM_W-1:0]    f_sum;
  logic [FACTOR_W-1:0] f_r;
  logic [DOC_W-1:0]    f_doc;
  logic                f_last;
  logic [P1_W-1:0]     prod1;
  logic [P2_W-1:0]     prod2;
  logic [MUL1_W-1:0]   mul1;
  logic [MUL2_W-1:0]   mul2;
  logic [SUM_W-1:0]    contrib;

  logic             out_kind;
  logic [DOC_W-1:0] out_doc;
  logic [AMT_W-1:0] out_amt;
  logic             out_free;
  logic             out_load;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (((state == ST_PLAN) && !pend_pre && pend_w) ||
                                 (state == ST_SEND));
  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign mul1     = MUL1_W'(f_sum) * MUL1_W'(f_r);
  assign mul2     = MUL2_W'(prod1) * MUL2_W'(job.factor);
  assign contrib  = (prod2 > P2_W'(SUM_MAX)) ? SUM_MAX : prod2[SUM_W-1:0];

  assign m_tdata  = OUT_TDATA_W'({out_amt, DOCF_W'(out_doc)});
  assign m_tuser  = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      pend_pre  <= 1'b0;
      pend_w    <= 1'b0;
      pend_post <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            pend_pre  <= head.pre_flush;
            pend_w    <= 1'b1;
            pend_post <= head.post_flush;
            state     <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          if (pend_pre) begin
            pend_pre <= 1'b0;
            state    <= ST_MUL1;
          end else if (pend_w) begin
            if (out_free) begin
              pend_w   <= 1'b0;
              state    <= pend_post ? ST_PLAN : ST_IDLE;
            end
          end else if (pend_post) begin
            pend_post <= 1'b0;
            state     <= ST_MUL1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_SEND;
        ST_SEND: begin
          if (out_free) begin
            state    <= f_last ? ST_IDLE : ST_PLAN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload side of the sequencer
  always_ff @(posedge clk) begin
    if (pop) job <= head;
    if (state == ST_PLAN) begin
      if (pend_pre) begin
        f_sum  <= job.pre_sum;
        f_r    <= RSQRT_ROM[job.pre_cnt];
        f_doc  <= job.pre_doc;
        f_last <= 1'b0;
      end else if (pend_w) begin
        if (out_free) begin
          out_kind <= KIND_WEIGHT;
          out_doc  <= job.doc;
          out_amt  <= job.weight_amt;
          m_tlast  <= !pend_post;
        end
      end else begin
        f_sum  <= job.post_sum;
        f_r    <= RSQRT_ROM[job.post_cnt];
        f_doc  <= job.doc;
        f_last <= 1'b1;
      end
    end
    if (state == ST_MUL1) prod1 <= mul1[MUL1_W-1:16];
    if (state == ST_MUL2) prod2 <= mul2[MUL2_W-1:16];
    if ((state == ST_SEND) && out_free) begin
      out_kind <= KIND_SCORE;
      out_doc  <= f_doc;
      out_amt  <= AMT_W'(contrib);
      m_tlast  <= f_last;
    end
  end

  a_score_nonneg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_kind == KIND_SCORE)) |-> !out_amt[AMT_W-1])
    else $error("negative document contribution");

  a_weight_neg_one: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_kind == KIND_WEIGHT) && out_amt[AMT_W-1])
      |-> (out_amt == NEG_ONE_Q16))
    else $error("negative weight other than minus one");

  a_pop_plans: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_PLAN) && pend_w)
    else $error("job taken without planning");

endmodule
`default_nettype wire

### design/hamming_embedding_posting_scorer_unit.sv
// top level of the hamming embedding posting scorer
`default_nettype none
// Each input beat is one posting; the block answers with its posting weight
// (word weight when the signature distance is within spatial_threshold, else
// -1.0) and, where a document run closes, the run contribution
// run_sum * rsqrt(run_count) * query_count_factor. Per beat the order is:
// flush of the previous document, posting weight, flush at list end; tlast
// marks the last result of a beat. The front end takes one posting per cycle
// (distance stage, then run update) while its four-entry job queue has room.
// The back-end sequencer handles one queued posting at a time and pops the
// next only from idle; a run flush adds an rsqrt table lookup, two registered
// multiplies and a send, and the receiver can stall any result.
module hamming_embedding_posting_scorer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // query_signature, word_weight, query_count_factor, doc_id, db_signature
  input  wire logic [hep_pkg::IN_TDATA_W-1:0]   s_tdata,
  // list_end
  input  wire logic                             s_tlast,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // result_doc, amount
  output logic [hep_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // kind
  output logic [0:0]                            m_tuser,
  // final_res
  output logic                                  m_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hep_pkg::THR_W-1:0]        cfg_data
);
  import hep_pkg::*;

  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t q_stat;

  hep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_stat    (q_stat)
  );

  hep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  hep_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### dv/hamming_embedding_posting_scorer_unit_tb.sv
// self-checking testbench for the hamming embedding posting scorer unit
module hamming_embedding_posting_scorer_unit_tb;
  import hep_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [SIG_W-1:0]    qsig;
    logic [WEIGHT_W-1:0] weight;
    logic [FACTOR_W-1:0] factor;
    logic [DOCF_W-1:0]   doc;
    logic [SIG_W-1:0]    dsig;
    logic                list_end;
  } posting_t;

  typedef struct packed {
    logic              kind;
    logic [DOCF_W-1:0] doc;
    logic [AMT_W-1:0]  amount;
    logic              fin;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [THR_W-1:0]       cfg_data = '0;

  hamming_embedding_posting_scorer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // scorer state as seen from outside
  logic [THR_W-1:0]  score_thr = SCORE_THR_RESET;
  logic [THR_W-1:0]  spatial_thr = SPATIAL_THR_RESET;
  logic [DOCF_W-1:0] run_doc = '0;
  logic [SUM_W-1:0]  run_sum = '0;
  int unsigned       run_count = 0;
  logic              run_open = 1'b0;

  posting_t postings_q[$];
  result_t  due_results[$];
  posting_t on_bus;

  logic        idle_en = 1'b1;
  int          hold_orders = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycles = 0;
  int          mismatches = 0;
  int          postings_sent = 0;
  int          lists_done = 0;
  int          beats_seen = 0;
  int          score_beats = 0;
  int          settings_used = 1;

  function automatic longint unsigned inv_sqrt_q16(input int unsigned n);
    longint unsigned r;
    longint unsigned c;
    if (n == 0) return 65536;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c * n <= 64'h1_0000_0000) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned run_score(input logic [FACTOR_W-1:0] factor);
    longint unsigned v;
    v = (longint'(run_sum) * inv_sqrt_q16(run_count)) >> 16;
    v = (v * longint'(factor)) >> 16;
    if (v > longint'(SUM_MAX)) v = longint'(SUM_MAX);
    return v;
  endfunction

  task automatic score_posting(input posting_t p);
    result_t           outs [3];
    int                n;
    int unsigned       hdist;
    logic [SUM_W:0]    grown;
    n = 0;
    hdist = $countones(p.qsig ^ p.dsig);
    // a doc change closes the previous run with the new posting's factor
    if (run_open && p.doc != run_doc) begin
      outs[n] = '{KIND_SCORE, run_doc, AMT_W'(run_score(p.factor)), 1'b0};
      n++;
      run_open = 1'b0;
    end
    if (!run_open) begin
      run_open = 1'b1;
      run_doc = p.doc;
      run_sum = '0;
      run_count = 0;
    end
    if (run_count < MAX_RUN) run_count++;
    if (hdist <= spatial_thr) begin
      if (hdist <= score_thr) begin
        grown = {1'b0, run_sum} + (SUM_W+1)'(p.weight);
        run_sum = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
      end
      outs[n] = '{KIND_WEIGHT, p.doc, AMT_W'(p.weight), 1'b0};
    end else begin
      outs[n] = '{KIND_WEIGHT, p.doc, NEG_ONE_Q16, 1'b0};
    end
    n++;
    if (p.list_end) begin
      outs[n] = '{KIND_SCORE, run_doc, AMT_W'(run_score(p.factor)), 1'b0};
      n++;
      run_open = 1'b0;
      run_sum = '0;
      run_count = 0;
      lists_done++;
    end
    outs[n-1].fin = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
  endtask

  // driver: one posting per beat from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        score_posting(on_bus);
        postings_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (postings_q.size() != 0 && !(idle_en && $urandom_range(99) < 30)) begin
          on_bus = postings_q.pop_front();
          s_tdata <= IN_TDATA_W'({on_bus.dsig, on_bus.doc, on_bus.factor,
                                  on_bus.weight, on_bus.qsig});
          s_tlast <= on_bus.list_end;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_beat();
    result_t got;
    result_t want;
    got = '{m_tuser[0], m_tdata[ODOC_LSB +: DOCF_W], m_tdata[OAMT_LSB +: AMT_W], m_tlast};
    beats_seen++;
    if (got.kind === KIND_SCORE) score_beats++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: kind %0d doc %h amount %h last %0d",
                 got.kind, got.doc, got.amount, got.fin);
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: expected kind %0d doc %h amount %h last %0d, %s%0d %h %h %0d",
                   beats_seen, want.kind, want.doc, want.amount, want.fin,
                   "got ", got.kind, got.doc, got.amount, got.fin);
      end
    end
  endtask

  // monitor: checks result beats and drives the receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (hold_seen != hold_orders) begin
        hold_seen <= hold_orders;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(idle_en && $urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, due_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [SIG_W-1:0] rand_sig();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SIG_W-1:0] flip_bits(input logic [SIG_W-1:0] sig,
                                                 input int unsigned d);
    logic [SIG_W-1:0] m;
    m = '0;
    while ($countones(m) < d) m[$urandom_range(SIG_W-1)] = 1'b1;
    return sig ^ m;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return WEIGHT_W'($urandom_range(262144));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FACTOR_W-1:0] rand_factor();
    if ($urandom_range(7) == 0) return FACTOR_W'($urandom_range(131071, 65537));
    return FACTOR_W'($urandom_range(65536));
  endfunction

  // distances cluster around both thresholds
  function automatic int unsigned pick_distance();
    int d;
    case ($urandom_range(3))
      0: d = int'(score_thr) + int'($urandom_range(6)) - 3;
      1: d = int'(spatial_thr) + int'($urandom_range(6)) - 3;
      2: d = int'($urandom_range(64));
      default: d = int'($urandom_range(4));
    endcase
    if (d < 0) d = 0;
    if (d > 64) d = 64;
    return d;
  endfunction

  task automatic add_posting(input logic [SIG_W-1:0] qsig, input logic [WEIGHT_W-1:0] weight,
                             input logic [FACTOR_W-1:0] factor, input logic [DOCF_W-1:0] doc,
                             input logic [SIG_W-1:0] dsig, input logic list_end);
    postings_q.push_back('{qsig, weight, factor, doc, dsig, list_end});
  endtask

  // lists of per-document runs, with some noise postings mixed in
  task automatic gen_lists(input int count);
    logic [SIG_W-1:0]  qsig;
    logic [DOCF_W-1:0] doc;
    int                left;
    int                run_len;
    logic              ends;
    qsig = rand_sig();
    doc = DOCF_W'($urandom);
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        add_posting(rand_sig(), $urandom, FACTOR_W'($urandom), DOCF_W'($urandom),
                    rand_sig(), 1'($urandom_range(1)));
        left--;
      end else begin
        run_len = $urandom_range(5, 1);
        if ($urandom_range(3) != 0) doc = DOCF_W'($urandom);
        for (int j = 0; j < run_len && left > 0; j++) begin
          ends = (j == run_len - 1) && ($urandom_range(2) == 0);
          add_posting(qsig, rand_weight(), rand_factor(), doc,
                      flip_bits(qsig, pick_distance()), ends);
          if (ends) qsig = rand_sig();
          left--;
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (postings_q.size() != 0 || due_results.size() != 0 || s_tvalid);
    // let the block settle before the next settings
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SCORE_THR) score_thr = val;
    else if (idx == REG_SPATIAL_THR) spatial_thr = val;
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] score, input logic [THR_W-1:0] spatial);
    wait_drained();
    write_reg(REG_SCORE_THR, score);
    write_reg(REG_SPATIAL_THR, spatial);
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    logic [SIG_W-1:0] qa;
    logic [SIG_W-1:0] alt;
    logic [DOCF_W-1:0] long_doc;
    qa = 64'h0123_4567_89AB_CDEF;
    alt = 64'hAAAA_AAAA_AAAA_AAAA;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset thresholds: edges of both windows, then run flush cases
    add_posting(qa, '0, '0, '0, qa, 1'b0);
    add_posting(qa, '1, FACTOR_W'(65536), '0, flip_bits(qa, 24), 1'b0);
    add_posting(qa, 32'h0001_0000, FACTOR_W'(65536), '0, flip_bits(qa, 25), 1'b0);
    add_posting(qa, 32'h0002_8000, FACTOR_W'(65536), '0, flip_bits(qa, 28), 1'b0);
    add_posting(qa, 32'h1234_5678, FACTOR_W'(65536), '0, flip_bits(qa, 29), 1'b0);
    add_posting('0, '1, FACTOR_W'(65536), '0, '1, 1'b1);
    add_posting('1, 32'h0001_0000, '1, '1, '1, 1'b0);
    add_posting('1, 32'h0001_0000, '1, '1, flip_bits('1, 1), 1'b0);
    // doc change flushes with this posting's factor
    add_posting(alt, 32'h8000_0000, FACTOR_W'(12345), DOCF_W'(1), alt, 1'b0);
    // doc change and list end on one posting
    add_posting(alt, 32'h0000_0001, '0, 24'h80_0000, ~alt, 1'b1);
    add_posting(qa, 32'h0003_0000, FACTOR_W'(46341), DOCF_W'(5), flip_bits(qa, 10), 1'b1);
    add_posting(qa, 32'h7FFF_FFFF, FACTOR_W'(1), DOCF_W'(5), qa, 1'b0);
    add_posting(qa, 32'h0000_FFFF, FACTOR_W'(32768), DOCF_W'(5), flip_bits(qa, 23), 1'b0);
    add_posting(qa, 32'h0000_FFFF, FACTOR_W'(65535), DOCF_W'(5), flip_bits(qa, 27), 1'b1);

    // receiver stalls long enough to back the block up
    set_thresholds(THR_W'(0), THR_W'(127));
    hold_orders <= hold_orders + 1;
    gen_lists(45);

    set_thresholds(THR_W'(64), THR_W'(64));
    gen_lists(22);
    wait_drained();
    @(negedge clk);
    gen_lists(23);

    // spatial window tighter than the score window
    set_thresholds(THR_W'(127), THR_W'(0));
    gen_lists(45);

    // one long run saturates both count and sum, with no idling
    set_thresholds(THR_W'(127), THR_W'(127));
    idle_en <= 1'b0;
    long_doc = DOCF_W'($urandom);
    for (int i = 0; i < 270; i++)
      add_posting(rand_sig(), '1, rand_factor(), long_doc, rand_sig(), i == 269);
    wait_drained();
    idle_en <= 1'b1;

    set_thresholds(THR_W'($urandom_range(127)), THR_W'($urandom_range(127)));
    gen_lists(30);

    wait_drained();
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0d results never arrived", due_results.size());
      mismatches += due_results.size();
    end
    $display("covered %0d postings in %0d lists over %0d threshold settings",
             postings_sent, lists_done, settings_used);
    $display("checked %0d result beats (%0d document scores), %0d mismatches",
             beats_seen, score_beats, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/hep_pkg.sv
design/hep_front.sv
design/hep_queue.sv
design/hep_back.sv
design/hamming_embedding_posting_scorer_unit.sv
dv/hamming_embedding_posting_scorer_unit_tb.sv
